[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the hash unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held low.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held low.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/s256_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s256_pkg
// Types, constants and round functions of the SHA-256 message hash unit.
// ----------------------------------------------------------------------------
package s256_pkg;

    localparam int unsigned OUT_TDATA_W = 40;
    localparam logic [7:0]  MARKER_BYTE = 8'h80;
    localparam logic [5:0]  LAST_ONE_BLOCK_POS = 6'd55;
    localparam logic [3:0]  LEN_HI_WORD = 4'd14;
    localparam logic [3:0]  LEN_LO_WORD = 4'd15;
    localparam logic [5:0]  LAST_ROUND = 6'd63;
    localparam logic [5:0]  FIRST_SCHED_ROUND = 6'd16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_INIT,
        ST_RB,
        ST_RA,
        ST_SUM,
        ST_OUT
    } s256_state_t;

    typedef logic [7:0][31:0] s256_digest_t;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_s0(input logic [31:0] x);
        big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_s1(input logic [31:0] x);
        big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_s0(input logic [31:0] x);
        small_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_s1(input logic [31:0] x);
        small_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                           input logic [31:0] g);
        choose = (e & f) ^ (~e & g);
    endfunction

    function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                             input logic [31:0] c);
        majority = (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

[hw/rtl/sha256_message_hash_unit.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// sha256_message_hash_unit
// SHA-256 digest of a byte stream, eight digest words per message.
// ----------------------------------------------------------------------------
// A message byte is taken whenever the unit is idle. The 64th byte of a
// block starts a compression (one load step in ST_INIT, 64 rounds of a read
// step in ST_RB and an update step in ST_RA, and the chaining add in ST_SUM),
// during which no request is taken; each round is split into the two steps
// by the two-read-port schedule memory, which holds the block words and the
// rolling message schedule. Ending a message writes one padding word for each
// word from the 0x80 marker to the end of the block (at most 16) and runs a
// compression; when the marker falls past byte 55, a further 16 padding words
// and a second compression follow. ST_OUT then hands the digest over once the
// output buffer is free. The digest is sent from a separate buffer, so the
// next message may start while it drains.
// ----------------------------------------------------------------------------
module sha256_message_hash_unit
    import s256_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] data_byte
    input  logic                   s_tuser,   // no_byte
    input  logic                   s_tlast,   // end_of_message
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic                   m_tlast    // last_word
);

    s256_state_t state_reg, state_next;

    logic [31:0] sched_mem [16];
    logic [31:0] rd0_reg, rd1_reg;
    logic [3:0]  raddr0, raddr1, waddr;
    logic [31:0] wdata;
    logic        we;

    logic [31:0] chain_reg [8];
    logic [31:0] var_reg [8];
    logic [63:0] len_reg;
    logic [5:0]  pos_reg, pos_next;
    logic [5:0]  round_reg;
    logic [31:0] acc_reg;
    logic [3:0]  wi_reg;
    logic        eom_reg, final_reg, mark_reg;
    logic [31:0] t1p_reg, t2_reg, sig_reg;

    logic        accept, has_byte;
    logic [4:0]  sh;
    logic [31:0] acc_next, marker_word, pad_word;
    logic [31:0] w, t1;
    logic [5:0]  round_a;
    logic        ob_load, ob_busy;
    s256_digest_t digest;

    assign accept   = s_tvalid && s_tready;
    assign has_byte = !s_tuser;
    assign sh       = {~pos_reg[1:0], 3'b000};
    assign pos_next = has_byte ? pos_reg + 6'd1 : pos_reg;
    assign acc_next = (pos_reg[1:0] == 2'd0) ? ({24'd0, s_tdata} << sh)
                                             : (acc_reg | ({24'd0, s_tdata} << sh));
    assign marker_word = (pos_reg[1:0] == 2'd0) ? {MARKER_BYTE, 24'd0}
                                                : (acc_reg | ({24'd0, MARKER_BYTE} << sh));

    always_comb begin
        if (mark_reg) begin
            pad_word = marker_word;
        end else if (final_reg && wi_reg == LEN_HI_WORD) begin
            pad_word = len_reg[63:32];
        end else if (final_reg && wi_reg == LEN_LO_WORD) begin
            pad_word = len_reg[31:0];
        end else begin
            pad_word = 32'd0;
        end
    end

    // Message word for the round completing now; rounds past 15 extend the schedule.
    assign w  = (round_reg < FIRST_SCHED_ROUND) ? rd0_reg : (sig_reg + rd0_reg + rd1_reg);
    assign t1 = t1p_reg + w;
    assign round_a = (state_reg == ST_INIT) ? 6'd0 : round_reg + 6'd1;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (has_byte && pos_reg == 6'd63) begin
                        state_next = ST_INIT;
                    end else if (s_tlast) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:  state_next = (wi_reg == 4'd15) ? ST_INIT : ST_PAD;
            ST_INIT: state_next = ST_RB;
            ST_RB:   state_next = ST_RA;
            ST_RA:   state_next = (round_reg == LAST_ROUND) ? ST_SUM : ST_RB;
            ST_SUM: begin
                if (final_reg) begin
                    state_next = ST_OUT;
                end else if (eom_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT:  state_next = ob_busy ? ST_OUT : ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs and memory controls.
    always_comb begin
        s_tready = 1'b0;
        ob_load  = 1'b0;
        we       = 1'b0;
        waddr    = pos_reg[5:2];
        wdata    = acc_next;
        raddr0   = round_a[3:0] + 4'd1;
        raddr1   = round_a[3:0] - 4'd2;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                we       = accept && has_byte && (pos_reg[1:0] == 2'd3);
            end
            ST_PAD: begin
                we    = 1'b1;
                waddr = wi_reg;
                wdata = pad_word;
            end
            ST_RB: begin
                raddr0 = round_reg[3:0];
                raddr1 = round_reg[3:0] - 4'd7;
            end
            ST_RA: begin
                we    = (round_reg >= FIRST_SCHED_ROUND);
                waddr = round_reg[3:0];
                wdata = w;
            end
            ST_OUT:  ob_load = !ob_busy;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            sched_mem[waddr] <= wdata;
        end
        rd0_reg <= sched_mem[raddr0];
        rd1_reg <= sched_mem[raddr1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            for (int i = 0; i < 8; i++) begin
                chain_reg[i] <= H_INIT[i];
                var_reg[i]   <= 32'd0;
            end
            len_reg   <= 64'd0;
            pos_reg   <= 6'd0;
            round_reg <= 6'd0;
            acc_reg   <= 32'd0;
            wi_reg    <= 4'd0;
            eom_reg   <= 1'b0;
            final_reg <= 1'b0;
            mark_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        if (has_byte) begin
                            pos_reg <= pos_next;
                            len_reg <= len_reg + 64'd8;
                            acc_reg <= acc_next;
                        end
                        if (s_tlast) begin
                            eom_reg   <= 1'b1;
                            mark_reg  <= 1'b1;
                            final_reg <= (pos_next <= LAST_ONE_BLOCK_POS)
                                         && !(has_byte && pos_reg == 6'd63);
                            wi_reg    <= pos_next[5:2];
                        end
                    end
                end
                ST_PAD: begin
                    mark_reg <= 1'b0;
                    wi_reg   <= wi_reg + 4'd1;
                end
                ST_INIT: begin
                    round_reg <= 6'd0;
                    for (int i = 0; i < 8; i++) begin
                        var_reg[i] <= chain_reg[i];
                    end
                end
                ST_RA: begin
                    round_reg  <= round_reg + 6'd1;
                    var_reg[7] <= var_reg[6];
                    var_reg[6] <= var_reg[5];
                    var_reg[5] <= var_reg[4];
                    var_reg[4] <= var_reg[3] + t1;
                    var_reg[3] <= var_reg[2];
                    var_reg[2] <= var_reg[1];
                    var_reg[1] <= var_reg[0];
                    var_reg[0] <= t1 + t2_reg;
                end
                ST_SUM: begin
                    for (int i = 0; i < 8; i++) begin
                        chain_reg[i] <= chain_reg[i] + var_reg[i];
                    end
                    // A message whose padding spills into a second block ends there.
                    if (eom_reg && !final_reg) begin
                        final_reg <= 1'b1;
                        wi_reg    <= 4'd0;
                    end
                end
                ST_OUT: begin
                    if (!ob_busy) begin
                        for (int i = 0; i < 8; i++) begin
                            chain_reg[i] <= H_INIT[i];
                        end
                        len_reg   <= 64'd0;
                        pos_reg   <= 6'd0;
                        eom_reg   <= 1'b0;
                        final_reg <= 1'b0;
                        mark_reg  <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Round terms and the schedule sum are registered in ST_RB for the update in ST_RA.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_RB) begin
            t1p_reg <= var_reg[7] + big_s1(var_reg[4])
                       + choose(var_reg[4], var_reg[5], var_reg[6]) + K_TABLE[round_reg];
            t2_reg  <= big_s0(var_reg[0]) + majority(var_reg[0], var_reg[1], var_reg[2]);
            sig_reg <= small_s0(rd0_reg) + small_s1(rd1_reg);
        end
    end

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            digest[i] = chain_reg[i];
        end
    end

    s256_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (ob_load),
        .digest   (digest),
        .busy     (ob_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    `ASSERT_IMPL(a_sum_after_last, aclk, aresetn, state_reg == ST_SUM, $past(round_reg) == LAST_ROUND, "chaining add before round 63")
    `ASSERT_IMPL(a_no_req_closing, aclk, aresetn, accept, !eom_reg, "request taken while a message is closing")
    `ASSERT_IMPL(a_sched_write, aclk, aresetn, (state_reg == ST_RA) && we, round_reg >= FIRST_SCHED_ROUND, "schedule written in an early round")

endmodule

[hw/rtl/s256_out_buf.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// s256_out_buf
// Holds one finished digest and sends its eight words on the result stream.
// ----------------------------------------------------------------------------
module s256_out_buf
    import s256_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  s256_digest_t           digest,
    output logic                   busy,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic                   m_tlast    // last_word
);

    logic [31:0] words_reg [8];
    logic        valid_reg, valid_next;
    logic [2:0]  idx_reg, idx_next;

    always_comb begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load) begin
            valid_next = 1'b1;
            idx_next   = 3'd0;
        end else if (valid_reg && m_tready) begin
            idx_next = idx_reg + 3'd1;
            if (idx_reg == 3'd7) begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 3'd0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int i = 0; i < 8; i++) begin
                words_reg[i] <= digest[i];
            end
        end
    end

    assign busy     = valid_reg;
    assign m_tvalid = valid_reg;
    assign m_tlast  = (idx_reg == 3'd7);
    assign m_tdata  = {5'd0, idx_reg, words_reg[idx_reg]};

    `ASSERT_IMPL(a_load_empty, aclk, aresetn, load, !valid_reg, "digest loaded over a pending one")
    `ASSERT_NEXT(a_load_start, aclk, aresetn, load, valid_reg && (idx_reg == 3'd0), "load did not start at word 0")
    `ASSERT_IMPL(a_fell_last, aclk, aresetn, $fell(valid_reg), $past(m_tlast && m_tready), "digest stream ended early")

endmodule
